/* hw/rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  // dividend |a| << FRAC_BITS, one quotient bit per cell
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int N_CELLS   = NUM_W;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MIN = 3'd4,
    ACT_MAX = 3'd5,
    ACT_INC = 3'd6,
    ACT_DEC = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     a_greater;
    logic                     a_less;
    logic                     operands_equal;
    logic                     divide_by_zero;
    logic                     overflowed;
  } rsp_t;

  // item state carried down the cell row
  typedef struct packed {
    logic [2:0]               action;
    logic [DATA_W-1:0]        a;
    logic [DATA_W-1:0]        b;
    logic                     neg;
    logic [2*DATA_W-1:0]      prod;
    logic [DATA_W-1:0]        den;
    logic [DATA_W-1:0]        rem;
    logic [NUM_W-1:0]         num;
  } cell_data_t;

endpackage

/* hw/rtl/fpa_front.sv */
// Entry stage: operand magnitudes, product and divider set-up.
`timescale 1ns / 1ps
module fpa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                req_valid,
  input  fpa_pkg::req_t       req,
  output logic                valid,
  output fpa_pkg::cell_data_t data
);

  logic [fpa_pkg::DATA_W-1:0] mag_a;
  logic [fpa_pkg::DATA_W-1:0] mag_b;
  fpa_pkg::cell_data_t        data_next;

  always_comb begin
    mag_a = req.operand_a[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-req.operand_a)
                                              : req.operand_a;
    mag_b = req.operand_b[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-req.operand_b)
                                              : req.operand_b;
    data_next.action = req.action;
    data_next.a      = req.operand_a;
    data_next.b      = req.operand_b;
    data_next.neg    = req.operand_a[fpa_pkg::DATA_W-1] ^ req.operand_b[fpa_pkg::DATA_W-1];
    data_next.prod   = {{fpa_pkg::DATA_W{1'b0}}, mag_a} * {{fpa_pkg::DATA_W{1'b0}}, mag_b};
    data_next.den    = mag_b;
    data_next.rem    = '0;
    data_next.num    = {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

/* hw/rtl/fpa_cell.sv */
// One restoring-division cell: one quotient bit per item per cycle while en is high.
`timescale 1ns / 1ps
module fpa_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                prev_valid,
  input  fpa_pkg::cell_data_t prev_data,
  output logic                valid,
  output fpa_pkg::cell_data_t data
);

  logic [fpa_pkg::DATA_W:0] trial;
  logic [fpa_pkg::DATA_W:0] diff;
  logic                     fits;
  fpa_pkg::cell_data_t      data_next;

  always_comb begin
    trial = {prev_data.rem, prev_data.num[fpa_pkg::NUM_W-1]};
    diff  = trial - {1'b0, prev_data.den};
    fits  = trial >= {1'b0, prev_data.den};
    data_next     = prev_data;
    data_next.rem = fits ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
    data_next.num = {prev_data.num[fpa_pkg::NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

/* hw/rtl/fpa_back.sv */
// Result stage: rounding, saturation, flags and the output register.
`timescale 1ns / 1ps
module fpa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                prev_valid,
  input  fpa_pkg::cell_data_t prev_data,
  output logic                rsp_valid,
  output fpa_pkg::rsp_t       rsp
);

  localparam logic [2*fpa_pkg::DATA_W-1:0] HALF = (2*fpa_pkg::DATA_W)'(1) <<
                                                  (fpa_pkg::FRAC_BITS - 1);
  localparam logic [fpa_pkg::DATA_W-1:0] MAXV = {1'b0, {(fpa_pkg::DATA_W-1){1'b1}}};
  localparam logic [fpa_pkg::DATA_W-1:0] MINV = {1'b1, {(fpa_pkg::DATA_W-1){1'b0}}};

  // {ovf, value} from a wide sum
  function automatic logic [fpa_pkg::DATA_W:0] sat_sum(input logic [fpa_pkg::DATA_W:0] s);
    if (s[fpa_pkg::DATA_W] != s[fpa_pkg::DATA_W-1]) begin
      return {1'b1, s[fpa_pkg::DATA_W] ? MINV : MAXV};
    end
    return {1'b0, s[fpa_pkg::DATA_W-1:0]};
  endfunction

  // {ovf, value} from magnitude and sign
  function automatic logic [fpa_pkg::DATA_W:0] sat_mag(input logic [2*fpa_pkg::DATA_W-1:0] m,
                                                       input logic neg);
    if (neg) begin
      if (m > (2*fpa_pkg::DATA_W)'(MINV)) begin
        return {1'b1, MINV};
      end
      return {1'b0, fpa_pkg::DATA_W'(-m)};
    end
    if (m > (2*fpa_pkg::DATA_W)'(MAXV)) begin
      return {1'b1, MAXV};
    end
    return {1'b0, m[fpa_pkg::DATA_W-1:0]};
  endfunction

  logic signed [fpa_pkg::DATA_W-1:0] sa;
  logic signed [fpa_pkg::DATA_W-1:0] sb;
  logic [fpa_pkg::DATA_W:0]          ea;
  logic [fpa_pkg::DATA_W:0]          eb;
  logic [2*fpa_pkg::DATA_W-1:0]      mul_mag;
  logic [2*fpa_pkg::DATA_W-1:0]      div_mag;
  logic                              round_up;
  logic [fpa_pkg::DATA_W:0]          res;
  logic                              dz;
  fpa_pkg::rsp_t                     rsp_next;

  always_comb begin
    sa       = $signed(prev_data.a);
    sb       = $signed(prev_data.b);
    ea       = {prev_data.a[fpa_pkg::DATA_W-1], prev_data.a};
    eb       = {prev_data.b[fpa_pkg::DATA_W-1], prev_data.b};
    mul_mag  = (prev_data.prod + HALF) >> fpa_pkg::FRAC_BITS;
    // tie away from zero: 2*rem >= den
    round_up = {prev_data.rem, 1'b0} >= {1'b0, prev_data.den};
    div_mag  = (2*fpa_pkg::DATA_W)'(prev_data.num) + (2*fpa_pkg::DATA_W)'(round_up);
    dz       = 1'b0;
    case (fpa_pkg::action_t'(prev_data.action))
      fpa_pkg::ACT_ADD: res = sat_sum(ea + eb);
      fpa_pkg::ACT_SUB: res = sat_sum(ea - eb);
      fpa_pkg::ACT_MUL: res = sat_mag(mul_mag, prev_data.neg);
      fpa_pkg::ACT_DIV: begin
        if (prev_data.den == '0) begin
          dz  = 1'b1;
          res = '0;
        end else begin
          res = sat_mag(div_mag, prev_data.neg);
        end
      end
      fpa_pkg::ACT_MIN: res = {1'b0, (sa < sb) ? prev_data.a : prev_data.b};
      fpa_pkg::ACT_MAX: res = {1'b0, (sa > sb) ? prev_data.a : prev_data.b};
      fpa_pkg::ACT_INC: res = sat_sum(ea + (fpa_pkg::DATA_W+1)'(1));
      fpa_pkg::ACT_DEC: res = sat_sum(ea - (fpa_pkg::DATA_W+1)'(1));
      default:          res = '0;
    endcase
    rsp_next.result_value   = res[fpa_pkg::DATA_W-1:0];
    rsp_next.overflowed     = res[fpa_pkg::DATA_W];
    rsp_next.divide_by_zero = dz;
    rsp_next.a_greater      = sa > sb;
    rsp_next.a_less         = sa < sb;
    rsp_next.operands_equal = prev_data.a == prev_data.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* hw/rtl/fixed_point_alu_core.sv */
// Top level of the signed fixed-point ALU: entry stage, divider cell row, result stage.
// Path: the entry register loads with the accepted item, then each divider cell in turn
// registers it, and the output register takes the result after the last cell.
// Throughput: one item per cycle while the output is not stalled; every action takes the same path, so order is kept.
// A stalled output freezes the whole pipe; req_stall follows it in the same cycle.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module fixed_point_alu_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fpa_pkg::rsp_t rsp
);

  // pipe moves whenever the output register is free or being drained
  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // stage 0 is the entry register, 1..N_CELLS the divider cells
  logic                cell_valid [fpa_pkg::N_CELLS+1];
  fpa_pkg::cell_data_t cell_data  [fpa_pkg::N_CELLS+1];

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .valid     (cell_valid[0]),
    .data      (cell_data[0])
  );

  for (genvar i = 0; i < fpa_pkg::N_CELLS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (cell_valid[i]),
      .prev_data  (cell_data[i]),
      .valid      (cell_valid[i+1]),
      .data       (cell_data[i+1])
    );
  end

  // rounding and saturation after the last cell, then the output register
  fpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .prev_valid (cell_valid[fpa_pkg::N_CELLS]),
    .prev_data  (cell_data[fpa_pkg::N_CELLS]),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

endmodule

/* hw/rtl/fpa_checker.sv */
// Port-level assertions for the fixed-point ALU and their bind.
`timescale 1ns / 1ps
module fpa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input fpa_pkg::rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({rsp.a_greater, rsp.a_less, rsp.operands_equal}))
    else $error("compare flags not exclusive");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0 && !rsp.overflowed)
    else $error("divide by zero result not clear");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without output back-pressure");

  a_rst: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
